>>> rtl/core/ipv6p_pkg.sv
// Package for the IPv6 text address parser.
// Holds the character class codes, the classified request type and the classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv6p_pkg;

  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_COLON = 2'd1;
  localparam logic [1:0] KIND_TERM  = 2'd2;
  localparam logic [1:0] KIND_DOT   = 2'd3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int GROUP_W   = 16;
  localparam int HALF_W    = 64;
  localparam int LEN_W     = 6;
  localparam int GROUPS    = 8;

  // Shortest and longest valid text: eight groups and seven colons.
  localparam logic [LEN_W-1:0] MIN_VALID_LEN = 6'd15;
  localparam logic [LEN_W-1:0] MAX_VALID_LEN = 6'd39;
  localparam logic [LEN_W-1:0] LEN_SAT       = 6'd63;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.kind  = KIND_TERM;
    r.digit = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      r.kind = KIND_DIGIT;
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.kind  = KIND_DIGIT;
      r.digit = c[3:0] + 4'd9;
    end else if (c == CH_COLON) begin
      r.kind = KIND_COLON;
    end else if (c == CH_DOT) begin
      r.kind = KIND_DOT;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ipv6p_front.sv
// Front stage of the IPv6 text parser: accepts characters and classifies them.
// Depends on ipv6p_pkg for the class type and classifier.
`timescale 1ns / 1ps
`default_nettype none

module ipv6p_front import ipv6p_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  output logic             push,
  input  wire logic        full,
  output char_class_t      push_item
);

  logic        held;
  char_class_t item;

  // The held request moves on whenever the queue has room.
  assign push      = held && !full;
  assign push_item = item;
  assign in_stall  = held && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= classify(character);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ipv6p_queue.sv
// Short queue between the classifier and the address builder.
// Depends on ipv6p_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module ipv6p_queue import ipv6p_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  char_class_t        push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output char_class_t        head,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  char_class_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];
  assign level    = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ipv6p_back.sv
// Back stage of the IPv6 text parser: builds groups and issues one result per terminator.
// Depends on ipv6p_pkg for class codes, widths and the request type.
`timescale 1ns / 1ps
`default_nettype none

module ipv6p_back import ipv6p_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               nonempty,
  input  char_class_t             head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [HALF_W-1:0]       address_high,
  output logic [HALF_W-1:0]       address_low,
  output logic [LEN_W-1:0]        text_length,
  output logic                    status
);

  logic [GROUP_W-1:0] groups [GROUPS-1];
  logic [GROUP_W-1:0] group_value;
  logic [2:0]         digit_count;
  logic [2:0]         group_count;
  logic [LEN_W-1:0]   char_count;
  logic               error_flag;

  logic is_term;
  logic bad;
  logic out_free;

  assign is_term  = (head.kind == KIND_TERM) || (head.kind == KIND_DOT);
  assign out_free = !out_valid || !out_stall;
  assign pop      = nonempty && (!is_term || out_free);

  assign bad = error_flag || (head.kind == KIND_DOT) || (digit_count == 3'd0) ||
               (group_count != 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_value <= '0;
      digit_count <= '0;
      group_count <= '0;
      char_count  <= '0;
      error_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(pop && is_term)) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (head.kind)
          KIND_DIGIT: begin
            if (char_count != LEN_SAT) begin
              char_count <= char_count + 1'b1;
            end
            if (!error_flag) begin
              if (digit_count == 3'd4) begin
                error_flag <= 1'b1;
              end else begin
                group_value <= {group_value[GROUP_W-5:0], head.digit};
                digit_count <= digit_count + 1'b1;
              end
            end
          end
          KIND_COLON: begin
            if (char_count != LEN_SAT) begin
              char_count <= char_count + 1'b1;
            end
            if (!error_flag) begin
              if (digit_count == 3'd0 || group_count == 3'd7) begin
                error_flag <= 1'b1;
              end else begin
                group_count <= group_count + 1'b1;
                group_value <= '0;
                digit_count <= '0;
              end
            end
          end
          default: begin
            // Terminator: start a fresh address after the result.
            out_valid   <= 1'b1;
            group_value <= '0;
            digit_count <= '0;
            group_count <= '0;
            char_count  <= '0;
            error_flag  <= 1'b0;
          end
        endcase
      end
    end
  end

  // Completed groups need no clearing: a valid result requires all seven written.
  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_COLON && !error_flag && digit_count != 3'd0 &&
        group_count != 3'd7) begin
      groups[group_count] <= group_value;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_term) begin
      if (bad) begin
        address_high <= '0;
        address_low  <= '0;
        text_length  <= '0;
        status       <= 1'b1;
      end else begin
        address_high <= {groups[0], groups[1], groups[2], groups[3]};
        address_low  <= {groups[4], groups[5], groups[6], group_value};
        text_length  <= char_count;
        status       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ipv6_text_address_parser_top.sv
// IPv6 text address parser, top level.
// Path: a terminator is registered in the front stage, then written into the queue,
// then popped by the back stage, which registers the result and raises out_valid.
// Throughput: one character per cycle; the queue absorbs output stalls until it fills.
// Reset: synchronous rst clears the stage, queue and parse state; no clearing pass.
// Depends on ipv6p_pkg, ipv6p_front, ipv6p_queue and ipv6p_back.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_text_address_parser_top import ipv6p_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         character,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [HALF_W-1:0]       address_high,
  output logic [HALF_W-1:0]       address_low,
  output logic [LEN_W-1:0]        text_length,
  output logic                    status
);

  logic        push;
  logic        full;
  logic        pop;
  logic        nonempty;
  char_class_t push_item;
  char_class_t head;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

  ipv6p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .push      (push),
    .full      (full),
    .push_item (push_item)
  );

  ipv6p_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head),
    .level     (level)
  );

  ipv6p_back u_back (
    .clk          (clk),
    .rst          (rst),
    .nonempty     (nonempty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .address_high (address_high),
    .address_low  (address_low),
    .text_length  (text_length),
    .status       (status)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_error_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (text_length == '0 && address_high == '0 &&
                               address_low == '0))
    else $error("error result carries nonzero fields");

  a_valid_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |-> (text_length >= MIN_VALID_LEN &&
                                text_length <= MAX_VALID_LEN))
    else $error("valid result with impossible length");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> full)
    else $error("input stalled while queue has room");

endmodule

`default_nettype wire
